// ===== hdl/es2c_pkg.sv =====
// package for the epoch seconds to calendar converter
// holds register indexes, divisor codes and reciprocals, the result layout and the month table
// no dependencies
package es2c_pkg;

  // configuration register indexes
  localparam logic [1:0] RegBaseYear     = 2'd0;
  localparam logic [1:0] RegEpochWeekday = 2'd1;
  localparam logic [1:0] RegNegInvalid   = 2'd2;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 12;

  // reset values of the configuration registers
  localparam logic [11:0] BaseYearReset     = 12'd1970;
  localparam logic [2:0]  EpochWeekdayReset = 3'd4;
  localparam logic        NegInvalidReset   = 1'b1;

  // what the shared divider is working on
  localparam logic [2:0] DivSec  = 3'd0;
  localparam logic [2:0] DivMin  = 3'd1;
  localparam logic [2:0] DivHour = 3'd2;
  localparam logic [2:0] DivWeek = 3'd3;
  localparam logic [2:0] DivBase = 3'd4;

  localparam int unsigned SubW     = 16;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [8:0]  day_of_year;
    logic [2:0]  weekday;
    logic [7:0]  year_offset;
    logic [3:0]  month;
    logic [15:0] day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } es2c_result_t;

  // constant divisor for each divider pass
  function automatic logic [5:0] div_const(input logic [2:0] sel);
    logic [5:0] d;
    case (sel)
      DivSec:  d = 6'd60;
      DivMin:  d = 6'd60;
      DivHour: d = 6'd24;
      DivWeek: d = 6'd7;
      DivBase: d = 6'd25;
      default: d = 6'd60;
    endcase
    return d;
  endfunction

  // rounded-up reciprocal of the odd part of each divisor, exact for dividends below 2^30
  // 15 with a shift of 34, 3 with 32, 7 with 33, 25 with 35
  function automatic logic [30:0] div_recip(input logic [2:0] sel);
    logic [30:0] m;
    case (sel)
      DivSec:  m = 31'd1145324613;
      DivMin:  m = 31'd1145324613;
      DivHour: m = 31'd1431655766;
      DivWeek: m = 31'd1227133514;
      DivBase: m = 31'd1374389535;
      default: m = 31'd1145324613;
    endcase
    return m;
  endfunction

  // month length in a common year, 0 is January
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] l;
    case (mon)
      4'd1:    l = 5'd28;
      4'd3:    l = 5'd30;
      4'd5:    l = 5'd30;
      4'd8:    l = 5'd30;
      4'd10:   l = 5'd30;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

// ===== hdl/epoch_seconds_to_calendar.sv =====
// epoch seconds to calendar converter with the gregorian leap rule, depends on es2c_pkg
// one sequencer shares a reciprocal multiplier for divide passes and a 16-bit subtractor
// calendar mode runs five divide passes, each a multiply then a remainder step, then steps
//   years and months with a closing step each; elapsed mode ends after the hour pass
// throughput: one transaction at a time, the next is taken in the cycle after hand-off;
//   reset: asynchronous active low, base year 1970, weekday 4, negative time rejected
module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] seconds_value
  input  logic [0:0]  s_axis_tuser_i,   // [0] elapsed_mode
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [5:0] second, [11:6] minute, [16:12] hour, [32:17] day_of_month,
  // [36:33] month, [44:37] year_offset, [47:45] weekday, [56:48] day_of_year
  output logic [63:0] m_axis_tdata_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [es2c_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [es2c_pkg::CfgDataW-1:0]  cfg_data_i
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_YEAR = 3'd2;
  localparam logic [2:0] S_MON  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // configuration registers
  logic [11:0] base_year_q;
  logic [2:0]  epoch_wd_q;
  logic        neg_inv_q;

  // sequencer and working registers
  logic [2:0]  state_q, state_d;
  logic [2:0]  sel_q, sel_d;          // which divider pass is running
  logic        cnt_q, cnt_d;          // divider phase, 0 multiply, 1 remainder
  logic [31:0] dvd_q, dvd_d;          // dividend of the running pass
  logic [31:0] quo_q, quo_d;          // quotient of the running pass
  logic        elapsed_q, elapsed_d;
  logic [15:0] days_q, days_d;        // remaining day count
  logic [12:0] year_q, year_d;        // calendar year being stepped
  logic [4:0]  r25_q, r25_d;          // year modulo 25, kept alongside year_q
  logic        leap_q, leap_d;        // leap flag of the final year
  logic [3:0]  mon_q, mon_d;
  es2c_pkg::es2c_result_t res_q, res_d;   // result under construction
  es2c_pkg::es2c_result_t out_q;          // output register
  logic        out_valid_q, out_valid_d;

  // shared subtractor
  logic [es2c_pkg::SubW-1:0] sub_a, sub_b;
  logic [es2c_pkg::SubW:0]   sub_diff;
  logic                      sub_borrow;

  logic [29:0] mul_n;       // dividend with the divisor's power of two shifted out
  logic [60:0] mul_p;
  logic [31:0] mul_quo;
  logic [5:0]  qd_prod;     // low bits of quotient times divisor
  logic [5:0]  div_rem;
  logic        leap_now;    // leap flag of year_q
  logic [4:0]  mlen;
  logic        out_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // divisible by 4 and not a century, or divisible by 400 (16 and 25)
  assign leap_now = (year_q[1:0] == 2'b00) && ((r25_q != 5'd0) || (year_q[3:0] == 4'd0));
  assign mlen     = es2c_pkg::month_len(mon_q) + {4'd0, (mon_q == 4'd1) && leap_q};

  // reciprocal division: 60 is 4 times 15, 24 is 8 times 3
  always_comb begin
    case (sel_q)
      es2c_pkg::DivSec, es2c_pkg::DivMin: begin
        mul_n = dvd_q[31:2];
      end
      es2c_pkg::DivHour: begin
        mul_n = {1'b0, dvd_q[31:3]};
      end
      default: begin
        // day count plus weekday and base year stay far below 2^30
        mul_n = dvd_q[29:0];
      end
    endcase
  end

  assign mul_p = {31'd0, mul_n} * {30'd0, es2c_pkg::div_recip(sel_q)};

  always_comb begin
    case (sel_q)
      es2c_pkg::DivSec, es2c_pkg::DivMin: mul_quo = {5'd0, mul_p[60:34]};
      es2c_pkg::DivHour:                  mul_quo = {3'd0, mul_p[60:32]};
      es2c_pkg::DivWeek:                  mul_quo = {4'd0, mul_p[60:33]};
      default:                            mul_quo = {6'd0, mul_p[60:35]};
    endcase
  end

  // the true remainder is below 64, so only the low six bits take part
  assign qd_prod = quo_q[5:0] * es2c_pkg::div_const(sel_q);

  // operand selection for the one subtractor
  always_comb begin
    case (state_q)
      S_YEAR: begin
        sub_a = days_q;
        sub_b = 16'd365 + {15'd0, leap_now};
      end
      S_MON: begin
        sub_a = days_q;
        sub_b = {11'd0, mlen};
      end
      default: begin
        sub_a = {10'd0, dvd_q[5:0]};
        sub_b = {10'd0, qd_prod};
      end
    endcase
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[es2c_pkg::SubW];

  assign div_rem  = sub_diff[5:0];

  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    cnt_d       = cnt_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    elapsed_d   = elapsed_q;
    days_d      = days_q;
    year_d      = year_q;
    r25_d       = r25_q;
    leap_d      = leap_q;
    mon_d       = mon_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          res_d     = '0;
          elapsed_d = s_axis_tuser_i[0];
          dvd_d     = s_axis_tdata_i;
          cnt_d     = 1'b0;
          sel_d     = es2c_pkg::DivSec;
          // negative time with rejection on gives an all-zero result
          if (neg_inv_q && s_axis_tdata_i[31]) begin
            state_d = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (!cnt_q) begin
          // quotient from the reciprocal product, remainder next cycle
          quo_d = mul_quo;
          cnt_d = 1'b1;
        end else begin
          cnt_d = 1'b0;
          dvd_d = quo_q;
          case (sel_q)
            es2c_pkg::DivSec: begin
              res_d.second = div_rem;
              sel_d        = es2c_pkg::DivMin;
            end
            es2c_pkg::DivMin: begin
              res_d.minute = div_rem;
              sel_d        = es2c_pkg::DivHour;
            end
            es2c_pkg::DivHour: begin
              res_d.hour = div_rem[4:0];
              days_d     = quo_q[15:0];
              if (elapsed_q) begin
                res_d.day_of_month = quo_q[15:0];
                state_d            = S_DONE;
              end else begin
                dvd_d = {15'd0, {1'b0, quo_q[15:0]} + {14'd0, epoch_wd_q}};
                sel_d = es2c_pkg::DivWeek;
              end
            end
            es2c_pkg::DivWeek: begin
              res_d.weekday = div_rem[2:0];
              dvd_d         = {20'd0, base_year_q};
              sel_d         = es2c_pkg::DivBase;
            end
            default: begin
              // base year modulo 25 seeds the leap tracking
              r25_d   = div_rem[4:0];
              year_d  = {1'b0, base_year_q};
              state_d = S_YEAR;
            end
          endcase
        end
      end

      S_YEAR: begin
        if (sub_borrow) begin
          leap_d            = leap_now;
          res_d.day_of_year = days_q[8:0];
          mon_d             = '0;
          state_d           = S_MON;
        end else begin
          days_d            = sub_diff[15:0];
          year_d            = year_q + 13'd1;
          res_d.year_offset = res_q.year_offset + 8'd1;
          r25_d             = (r25_q == 5'd24) ? 5'd0 : r25_q + 5'd1;
        end
      end

      S_MON: begin
        if (sub_borrow || (mon_q == 4'd11)) begin
          res_d.month        = mon_q;
          res_d.day_of_month = {11'd0, days_q[4:0] + 5'd1};
          state_d            = S_DONE;
        end else begin
          days_d = sub_diff[15:0];
          mon_d  = mon_q + 4'd1;
        end
      end

      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      base_year_q <= es2c_pkg::BaseYearReset;
      epoch_wd_q  <= es2c_pkg::EpochWeekdayReset;
      neg_inv_q   <= es2c_pkg::NegInvalidReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      // writes to unknown indexes are dropped
      if (cfg_valid_i) begin
        case (cfg_index_i)
          es2c_pkg::RegBaseYear:     base_year_q <= cfg_data_i[11:0];
          es2c_pkg::RegEpochWeekday: epoch_wd_q  <= cfg_data_i[2:0];
          es2c_pkg::RegNegInvalid:   neg_inv_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    sel_q     <= sel_d;
    cnt_q     <= cnt_d;
    dvd_q     <= dvd_d;
    quo_q     <= quo_d;
    elapsed_q <= elapsed_d;
    days_q    <= days_d;
    year_q    <= year_d;
    r25_q     <= r25_d;
    leap_q    <= leap_d;
    mon_q     <= mon_d;
    res_q     <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

`ifndef ASSERT_OFF
  // month stepping never runs past december
  a_mon_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MON) |-> (mon_q <= 4'd11))
    else $error("month index out of range");

  // the modulo-25 tracker stays in range while years are stepped
  a_r25_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_YEAR) |-> (r25_q < 5'd25))
    else $error("year modulo 25 out of range");

  // negative time skips all arithmetic
  a_neg_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && neg_inv_q && s_axis_tdata_i[31])
    |=> (state_q == S_DONE))
    else $error("negative time did not go straight to hand-off");

  // a taken result without a new one behind it leaves the output empty
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !out_load) |=> !m_axis_tvalid_o)
    else $error("result repeated after transaction");

  // the output register is never overwritten while a result is stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !out_load)
    else $error("stalled result overwritten");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking bench for the epoch seconds to calendar converter
// drives timestamps and register settings, predicts each calendar result and checks it
// depends on es2c_pkg and epoch_seconds_to_calendar
module testbench;

  // index with no register behind it, writes there must change nothing
  localparam logic [es2c_pkg::CfgIndexW-1:0] RegSpare = 2'd3;

  // covers the worst-case conversion plus a long stall on each side, taken
  // several times over for roughly 1000 transactions
  localparam int unsigned CycleLimit  = 4_000_000;
  // well beyond the longest conversion, used as the quiet tail at the end
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned RandomPerSetting = 125;

  // month lengths in a common year, january first
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [31:0] secs;
    logic        elapsed;
  } conv_request_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [31:0]                    s_axis_tdata_i  = '0;   // [31:0] seconds_value
  logic [0:0]                     s_axis_tuser_i  = '0;   // [0] elapsed_mode
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  // [5:0] second, [11:6] minute, [16:12] hour, [32:17] day_of_month,
  // [36:33] month, [44:37] year_offset, [47:45] weekday, [56:48] day_of_year
  logic [63:0]                    m_axis_tdata_o;
  logic                           cfg_valid_i     = 1'b0;
  logic                           cfg_ready_o;
  logic [es2c_pkg::CfgIndexW-1:0] cfg_index_i     = '0;
  logic [es2c_pkg::CfgDataW-1:0]  cfg_data_i      = '0;

  // bench copy of the configuration registers, updated on each accepted write
  logic [11:0] cal_base_year   = es2c_pkg::BaseYearReset;
  logic [2:0]  cal_epoch_wday  = es2c_pkg::EpochWeekdayReset;
  logic        cal_neg_invalid = es2c_pkg::NegInvalidReset;

  conv_request_t          queued_requests [$];
  es2c_pkg::es2c_result_t expected_dates  [$];

  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned requests_taken = 0;
  int unsigned elapsed_taken  = 0;
  int unsigned negative_taken = 0;
  int unsigned dates_checked  = 0;
  int unsigned cfg_writes     = 0;
  int unsigned settings_run   = 1;

  // handshake flags seen at the last rising edge, read by the drivers
  bit req_taken = 1'b0;
  bit res_taken = 1'b0;

  int unsigned hold_off   = 0;
  int unsigned stall_left = 0;
  int          in_calm    = 0;
  int          out_calm   = 0;

  epoch_seconds_to_calendar uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // gmtime style split of one timestamp under the current register copy
  function automatic es2c_pkg::es2c_result_t convert_epoch(input logic [31:0] secs,
                                                           input logic elapsed);
    es2c_pkg::es2c_result_t r;
    logic [31:0]  rest;
    int unsigned  days, year, yoff, mon, mlen;
    bit           leap;
    r = '0;
    // negative time with rejection on gives an all-zero result in either mode
    if (cal_neg_invalid && secs[31]) return r;
    r.second = 6'(secs % 60);
    rest     = secs / 60;
    r.minute = 6'(rest % 60);
    rest     = rest / 60;
    r.hour   = 5'(rest % 24);
    days     = rest / 24;
    if (elapsed) begin
      r.day_of_month = 16'(days);
      return r;
    end
    // an epoch weekday of seven still wraps modulo seven
    r.weekday = 3'((days + cal_epoch_wday) % 7);
    year = cal_base_year;
    yoff = 0;
    forever begin
      leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
      if (days < 365 + leap) break;
      days -= 365 + leap;
      year++;
      yoff++;
    end
    r.year_offset = 8'(yoff);
    r.day_of_year = 9'(days);
    mon = 0;
    while (mon < 11) begin
      mlen = MonthDays[mon] + ((mon == 1) ? leap : 0);
      if (days < mlen) break;
      days -= mlen;
      mon++;
    end
    r.month        = 4'(mon);
    r.day_of_month = 16'(days + 1);
    return r;
  endfunction

  // mostly short gaps, now and then a long one or a run with none at all
  function automatic int unsigned pick_gap(inout int calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  // mix of raw 32-bit values, positive-only values and stamps built from a day and a time of day
  function automatic conv_request_t random_request();
    conv_request_t q;
    int unsigned   pick, days, tod;
    pick      = $urandom_range(0, 9);
    q.elapsed = ($urandom_range(0, 3) == 0);
    if (pick < 3) begin
      q.secs = $urandom();
    end else if (pick < 5) begin
      q.secs = $urandom() & 32'h7FFF_FFFF;
    end else begin
      days = $urandom_range(0, 49710);
      case ($urandom_range(0, 2))
        0:       tod = 0;
        1:       tod = 86399;
        default: tod = $urandom_range(0, 86399);
      endcase
      q.secs = days * 86400 + tod;
    end
    return q;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void queue_request(input logic [31:0] secs, input logic elapsed);
    conv_request_t q;
    q.secs    = secs;
    q.elapsed = elapsed;
    queued_requests.push_back(q);
  endfunction

  // one register write, the bench copy follows at the accepting edge
  task automatic write_register(input logic [es2c_pkg::CfgIndexW-1:0] idx,
                                input logic [es2c_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      es2c_pkg::RegBaseYear:     cal_base_year   = data;
      es2c_pkg::RegEpochWeekday: cal_epoch_wday  = data[2:0];
      es2c_pkg::RegNegInvalid:   cal_neg_invalid = data[0];
      default:                   ;
    endcase
    cfg_writes++;
  endtask

  // nothing queued, nothing on the input bus and every result back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (queued_requests.size() != 0 || s_axis_tvalid_i || expected_dates.size() != 0);
  endtask

  // new register setting between phases, upper data bits carry noise where unused
  task automatic apply_setting(input logic [11:0] base, input logic [2:0] wday,
                               input logic neg);
    wait_idle();
    write_register(RegSpare, es2c_pkg::CfgDataW'($urandom()));
    write_register(es2c_pkg::RegBaseYear, base);
    write_register(es2c_pkg::RegEpochWeekday, {9'($urandom()), wday});
    write_register(es2c_pkg::RegNegInvalid, {11'($urandom()), neg});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  task automatic queue_random(input int unsigned count);
    conv_request_t q;
    repeat (count) begin
      q = random_request();
      queued_requests.push_back(q);
    end
  endtask

  // input side: next item from the queue, held until taken, then an idle gap
  always @(negedge clk_i) begin : feed_requests
    logic          next_valid;
    conv_request_t q;
    next_valid = s_axis_tvalid_i;
    if (!rst_ni) begin
      next_valid = 1'b0;
    end else if (!s_axis_tvalid_i || req_taken) begin
      if (hold_off > 0) begin
        hold_off--;
        next_valid = 1'b0;
      end else if (queued_requests.size() > 0) begin
        q = queued_requests.pop_front();
        s_axis_tdata_i <= q.secs;
        s_axis_tuser_i <= q.elapsed;
        next_valid = 1'b1;
        hold_off = pick_gap(in_calm);
      end else begin
        next_valid = 1'b0;
      end
    end
    s_axis_tvalid_i <= next_valid;
  end

  // result side: stall after a taken result and at random moments in between
  always @(negedge clk_i) begin : drain_results
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        if (res_taken) stall_left = pick_gap(out_calm);
        else if ($urandom_range(0, 63) == 0) stall_left = pick_gap(out_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // both handshakes are seen here: requests are predicted, results checked in order
  always @(posedge clk_i) begin : watch_streams
    es2c_pkg::es2c_result_t got, want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      req_taken = s_axis_tvalid_i && s_axis_tready_o;
      res_taken = m_axis_tvalid_o && m_axis_tready_i;
      if (req_taken) begin
        expected_dates.push_back(convert_epoch(s_axis_tdata_i, s_axis_tuser_i[0]));
        requests_taken++;
        if (s_axis_tuser_i[0]) elapsed_taken++;
        if (cal_neg_invalid && s_axis_tdata_i[31]) negative_taken++;
      end
      if (res_taken) begin
        got = es2c_pkg::es2c_result_t'(m_axis_tdata_o);
        if (expected_dates.size() == 0) begin
          $error("result transaction with no request outstanding: %h", m_axis_tdata_o);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          check_field("second", want.second, got.second);
          check_field("minute", want.minute, got.minute);
          check_field("hour", want.hour, got.hour);
          check_field("day_of_month", want.day_of_month, got.day_of_month);
          check_field("month", want.month, got.month);
          check_field("year_offset", want.year_offset, got.year_offset);
          check_field("weekday", want.weekday, got.weekday);
          check_field("day_of_year", want.day_of_year, got.day_of_year);
          dates_checked++;
        end
      end
    end
  end

  initial begin : run_phases
    int unsigned k;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: 1970 base, thursday, negative time rejected
    queue_request(32'd0, 1'b0);
    queue_request(32'd0, 1'b1);
    queue_request(32'd59, 1'b0);
    queue_request(32'd60, 1'b0);
    queue_request(32'd3599, 1'b0);
    queue_request(32'd86399, 1'b0);
    queue_request(32'd86400, 1'b0);
    // around the leap day of a year divisible by 400
    queue_request(32'd951782399, 1'b0);
    queue_request(32'd951782400, 1'b0);
    queue_request(32'd951868800, 1'b0);
    queue_request(32'd978307199, 1'b0);
    queue_request(32'h7FFF_FFFF, 1'b0);
    queue_request(32'h7FFF_FFFF, 1'b1);
    // bit 31 set with rejection on, all-zero in both modes
    queue_request(32'h8000_0000, 1'b0);
    queue_request(32'h8000_0000, 1'b1);
    queue_request(32'hFFFF_FFFF, 1'b0);
    queue_request(32'hFFFF_FFFF, 1'b1);

    // 1900 base, a century year that is not a leap year, full unsigned range
    apply_setting(12'd1900, 3'd1, 1'b0);
    queue_request(32'd59 * 32'd86400, 1'b0);
    queue_request(32'd60 * 32'd86400 - 32'd1, 1'b0);
    queue_request(32'h8000_0000, 1'b0);
    queue_request(32'hFFFF_FFFF, 1'b0);
    queue_request(32'hFFFF_FFFF, 1'b1);
    queue_random(RandomPerSetting);

    // register extremes: base year zero and all ones, weekday seven acting as sunday
    apply_setting(12'd0, 3'd7, 1'b0);
    queue_random(RandomPerSetting);
    apply_setting(12'd4095, 3'd0, 1'b1);
    queue_random(RandomPerSetting);
    apply_setting(12'd2099, 3'd6, 1'b0);
    queue_random(RandomPerSetting);
    apply_setting(12'd2000, 3'd6, 1'b1);
    queue_random(RandomPerSetting);
    for (k = 0; k < 2; k++) begin
      apply_setting(12'($urandom()), 3'($urandom()), 1'($urandom()));
      queue_random(RandomPerSetting);
    end
    // back to the reset values
    apply_setting(es2c_pkg::BaseYearReset, es2c_pkg::EpochWeekdayReset,
                  es2c_pkg::NegInvalidReset);
    queue_random(RandomPerSetting);

    wait_idle();
    // any stray result in this window is flagged by the monitor
    repeat (DrainCycles) @(posedge clk_i);

    $display("converted %0d timestamps (%0d elapsed, %0d negative) under %0d settings",
             requests_taken, elapsed_taken, negative_taken, settings_run);
    $display("checked %0d results field by field, %0d register writes, %0d mismatches",
             dates_checked, cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/es2c_pkg.sv
hdl/epoch_seconds_to_calendar.sv
tb/sv/testbench.sv
